// ----- rtl/core/hash_index_linear_probe_insert_assert.svh -----
// Assertion macros shared by the hash index insert RTL.
`ifndef HASH_INDEX_LINEAR_PROBE_INSERT_ASSERT_SVH
`define HASH_INDEX_LINEAR_PROBE_INSERT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HILP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HILP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/hilp_pkg.sv -----
// Shared constants for the hash index linear probe insert block.
package hilp_pkg;

    // Default table geometry
    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int INDEX_BITS_DEF = 16;

    // Fixed field widths
    localparam int HASH_BITS       = 32;
    localparam int SLOT_FIELD_BITS = 10;
    localparam int CFG_BITS        = 4;

    // Size register reset value
    localparam logic [CFG_BITS-1:0] CFG_SIZE_RESET = 4'd10;

    // Result status codes
    localparam logic STATUS_STORED  = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

endpackage

// ----- rtl/core/hilp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hilp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/hilp_front.sv -----
// Front end: accepts inserts, computes home slot and size mask, queues them.
`include "hash_index_linear_probe_insert_assert.svh"

module hilp_front #(
    parameter int SLOT_BITS  = 10,
    parameter int INDEX_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [hilp_pkg::CFG_BITS-1:0]  size_log2,
    input  logic                           accept_en,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hilp_pkg::HASH_BITS-1:0] s_key_hash,
    input  logic [INDEX_BITS-1:0]          s_key_index,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [SLOT_BITS-1:0]           q_home,
    output logic [SLOT_BITS-1:0]           q_mask,
    output logic [INDEX_BITS-1:0]          q_value
);

    localparam int QDEPTH = 2;

    logic [SLOT_BITS-1:0]  mask;
    logic [SLOT_BITS-1:0]  home;
    logic [SLOT_BITS-1:0]  home_q_reg  [QDEPTH];
    logic [SLOT_BITS-1:0]  mask_q_reg  [QDEPTH];
    logic [INDEX_BITS-1:0] value_q_reg [QDEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  push, pop;

    // Size mask, saturated at the physical table size
    always_comb begin
        for (int i = 0; i < SLOT_BITS; i++) begin
            mask[i] = (int'(size_log2) > i);
        end
    end

    assign home = s_key_hash[SLOT_BITS-1:0] & mask;

    // Queue handshake
    assign s_ready = accept_en && (cnt_reg != 2'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;

    assign q_home  = home_q_reg[rd_ptr_reg];
    assign q_mask  = mask_q_reg[rd_ptr_reg];
    assign q_value = value_q_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            home_q_reg[wr_ptr_reg]  <= home;
            mask_q_reg[wr_ptr_reg]  <= mask;
            value_q_reg[wr_ptr_reg] <= s_key_index;
        end
    end

    `HILP_ASSERT_NOW(a_front_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 2'(QDEPTH),
        "front queue count out of range")
    `HILP_ASSERT_NOW(a_front_no_overflow, aclk, aresetn, push, cnt_reg != 2'(QDEPTH),
        "front queue written while full")
    `HILP_ASSERT_NEXT(a_front_cnt_track, aclk, aresetn, push && !pop,
        cnt_reg == $past(cnt_reg) + 2'd1, "front queue count lost a transaction")

endmodule

// ----- rtl/core/hilp_back.sv -----
// Back end: clears the slot store, checks fill level, probes and writes slots.
`include "hash_index_linear_probe_insert_assert.svh"

module hilp_back #(
    parameter int SLOT_BITS  = 10,
    parameter int INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [SLOT_BITS-1:0]  q_home,
    input  logic [SLOT_BITS-1:0]  q_mask,
    input  logic [INDEX_BITS-1:0] q_value,
    output logic                  clear_done,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_BITS-1:0]  m_slot,
    output logic                  m_status
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [SLOT_BITS-1:0]  pos_reg, pos_next;
    logic [SLOT_BITS-1:0]  tries_reg, tries_next;
    logic [SLOT_BITS-1:0]  mask_reg, mask_next;
    logic [INDEX_BITS-1:0] value_reg, value_next;
    logic [SLOT_BITS:0]    used_reg, used_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SLOT_BITS-1:0]  m_slot_reg, m_slot_next;
    logic                  m_status_reg, m_status_next;

    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_waddr;
    logic [INDEX_BITS-1:0] ram_wdata;
    logic [SLOT_BITS-1:0]  ram_raddr;
    logic [INDEX_BITS-1:0] ram_rdata;
    logic [SLOT_BITS-1:0]  step_pos;
    logic                  out_free;
    logic                  hit;

    hilp_ram #(
        .WIDTH (INDEX_BITS),
        .DEPTH (1 << SLOT_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign step_pos   = (pos_reg + 1'b1) & mask_reg;
    assign hit        = (pos_reg != '0) && (ram_rdata == '0);
    assign clear_done = (state_reg != ST_CLEAR);

    // Sequencer: clear pass, then an issue state and one probe per cycle
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pos_next      = pos_reg;
        tries_next    = tries_reg;
        mask_next     = mask_reg;
        value_next    = value_reg;
        used_next     = used_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_slot_next   = m_slot_reg;
        m_status_next = m_status_reg;
        q_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = '0;
        ram_raddr     = q_home;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Start only when the result register will be free at finish
                if (q_valid && out_free) begin
                    q_ready    = 1'b1;
                    mask_next  = q_mask;
                    value_next = q_value;
                    if (used_reg > {1'b0, q_mask}) begin
                        m_valid_next  = 1'b1;
                        m_slot_next   = '0;
                        m_status_next = hilp_pkg::STATUS_REFUSED;
                    end else begin
                        pos_next   = q_home;
                        tries_next = '0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                ram_raddr = step_pos;
                if (hit) begin
                    ram_we        = 1'b1;
                    ram_waddr     = pos_reg;
                    ram_wdata     = value_reg;
                    used_next     = used_reg + 1'b1;
                    m_valid_next  = 1'b1;
                    m_slot_next   = pos_reg;
                    m_status_next = hilp_pkg::STATUS_STORED;
                    state_next    = ST_IDLE;
                end else if (tries_reg == mask_reg) begin
                    // Full pass without an empty slot
                    m_valid_next  = 1'b1;
                    m_slot_next   = '0;
                    m_status_next = hilp_pkg::STATUS_REFUSED;
                    state_next    = ST_IDLE;
                end else begin
                    pos_next   = step_pos;
                    tries_next = tries_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            used_reg     <= (SLOT_BITS+1)'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        tries_reg    <= tries_next;
        mask_reg     <= mask_next;
        value_reg    <= value_next;
        m_slot_reg   <= m_slot_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

    `HILP_ASSERT_NOW(a_back_no_slot0_write, aclk, aresetn,
        ram_we && (state_reg != ST_CLEAR), ram_waddr != '0,
        "reserved slot zero written")
    `HILP_ASSERT_NOW(a_back_used_nonzero, aclk, aresetn, 1'b1, used_reg != '0,
        "use counter lost its reserved slot")
    `HILP_ASSERT_NOW(a_back_stored_slot, aclk, aresetn,
        m_valid_reg && (m_status_reg == hilp_pkg::STATUS_STORED), m_slot_reg != '0,
        "stored result reports slot zero")
    `HILP_ASSERT_NOW(a_back_tries_bound, aclk, aresetn,
        state_reg == ST_PROBE, tries_reg <= mask_reg,
        "probe count ran past table size")
    `HILP_ASSERT_NOW(a_back_no_accept_clear, aclk, aresetn,
        state_reg == ST_CLEAR, !q_ready,
        "item taken during clear pass")

endmodule

// ----- rtl/core/hash_index_linear_probe_insert.sv -----
// Hash index insert with linear probing: front queue, probe engine, slot store.
// An insert is taken in the idle state, which reads its home slot, then probes
// slot after slot until one is empty or all slots of its masked table are
// tried; an insert refused by the use counter is answered from the idle state.
// The rate is set by the probe loop on the single read port of the slot store.
// After reset the store is cleared one slot per cycle while s_ready stays low;
// configuration writes are taken at any time. A front queue of two entries and
// the result register let inputs be taken while a result waits on m_ready.
module hash_index_linear_probe_insert #(
    parameter int MAX_SLOTS  = hilp_pkg::MAX_SLOTS_DEF,
    parameter int INDEX_BITS = hilp_pkg::INDEX_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hilp_pkg::CFG_BITS-1:0]        cfg_table_size_log2,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [hilp_pkg::HASH_BITS-1:0]       s_key_hash,
    input  logic [INDEX_BITS-1:0]                s_key_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hilp_pkg::SLOT_FIELD_BITS-1:0] m_slot,
    output logic                                 m_status
);

    localparam int SLOT_BITS = $clog2(MAX_SLOTS);

    logic [hilp_pkg::CFG_BITS-1:0] size_log2_reg;
    logic                          clear_done;
    logic                          q_valid, q_ready;
    logic [SLOT_BITS-1:0]          q_home, q_mask;
    logic [INDEX_BITS-1:0]         q_value;
    logic [SLOT_BITS-1:0]          slot_int;
    logic [SLOT_BITS+hilp_pkg::SLOT_FIELD_BITS-1:0] slot_wide;

    // Size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= hilp_pkg::CFG_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            size_log2_reg <= cfg_table_size_log2;
        end
    end

    hilp_front #(
        .SLOT_BITS  (SLOT_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .size_log2   (size_log2_reg),
        .accept_en   (clear_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_hash  (s_key_hash),
        .s_key_index (s_key_index),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_home      (q_home),
        .q_mask      (q_mask),
        .q_value     (q_value)
    );

    hilp_back #(
        .SLOT_BITS  (SLOT_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_home     (q_home),
        .q_mask     (q_mask),
        .q_value    (q_value),
        .clear_done (clear_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_slot     (slot_int),
        .m_status   (m_status)
    );

    // Fit the internal slot number to the result field
    assign slot_wide = {{hilp_pkg::SLOT_FIELD_BITS{1'b0}}, slot_int};
    assign m_slot    = slot_wide[hilp_pkg::SLOT_FIELD_BITS-1:0];

endmodule
